### hdl/pdgc_pkg.sv
// Package for the pixel dark/gain correction block.
// Field widths, saturation limits, table geometry and code values.
// No dependencies.
package pdgc_pkg;

  localparam int ADC_W      = 14;
  localparam int PIX_W      = 14;
  localparam int CAL_GAIN_W = 16;
  localparam int OUT_W      = 15;
  localparam int DIFF_W     = 15;

  // Two gain ranges of 2**PIX_W pixels each.
  localparam int TABLE_PIXELS = 1 << PIX_W;
  localparam int TABLE_DEPTH  = 2 * TABLE_PIXELS;

  localparam int SAT_HI = 16383;
  localparam int SAT_LO = -16384;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_DARK_ENABLE = 2'd0,
    CFG_GAIN_ENABLE = 2'd1,
    CFG_LOAD_ENABLE = 2'd2
  } cfg_addr_t;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_CAL   = 1'b1
  } item_kind_t;

  // Pipeline depth from input accept to output register, in items.
  localparam int PIPE_DEPTH = 4;

endpackage

### hdl/pdgc_if.sv
// Channel interfaces of the pixel dark/gain correction block:
// pixel/calibration input, corrected result output, configuration write.
// Depends on pdgc_pkg.
interface pdgc_pixel_if import pdgc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [ADC_W-1:0]      adc;
  logic                  gain_bit;
  logic                  last_in;
  logic [PIX_W-1:0]      cal_index;
  logic                  cal_range;
  logic [ADC_W-1:0]      cal_dark;
  logic [CAL_GAIN_W-1:0] cal_gain;

  modport source (output valid, kind, adc, gain_bit, last_in, cal_index, cal_range,
                  cal_dark, cal_gain, input ready);
  modport sink   (input valid, kind, adc, gain_bit, last_in, cal_index, cal_range,
                  cal_dark, cal_gain, output ready);
  modport mon    (input valid, ready, kind, adc, gain_bit, last_in, cal_index, cal_range,
                  cal_dark, cal_gain);
endinterface

interface pdgc_result_if import pdgc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [OUT_W-1:0]  corrected;
  logic                     gain_out;
  logic                     last_out;

  modport source (output valid, corrected, gain_out, last_out, input ready);
  modport sink   (input valid, corrected, gain_out, last_out, output ready);
  modport mon    (input valid, ready, corrected, gain_out, last_out);
endinterface

interface pdgc_cfg_if import pdgc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
  modport mon    (input valid, ready, addr, data);
endinterface

### hdl/pdgc_ram.sv
// Generic simple dual-port RAM: one write port, one read port,
// registered read data. No dependencies.
module pdgc_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/pixel_dark_gain_correction_core.sv
// Per-pixel dark subtraction and gain correction core (top level).
// Depends on pdgc_pkg, pdgc_if.sv interfaces and pdgc_ram.
//
// Usage:
//   pixel_in carries pixel items (kind = pixel) and calibration items
//   (kind = cal). A calibration item writes {cal_dark, cal_gain} at entry
//   {cal_range, cal_index} of the table when load_enable is set, and yields
//   no result. A pixel item reads the entry {gain_bit, pixel counter}, and
//   gives one item on result_out: corrected, gain_out, last_out.
//   cfg writes registers 0 dark_enable, 1 gain_enable, 2 load_enable (bit 0
//   of data); cfg is always ready. Write it only while the block is idle.
// Timing:
//   One item per cycle sustained while result_out.ready stays high. A pixel
//   item's table read happens at the edge that accepts it, then come dark
//   subtract, gain multiply, and shift and saturate into the output register.
//   The single table read port sets the rate.
// Reset:
//   Clears the registers, the pixel counter and the pipeline. The table is
//   not cleared; entries read by pixel items must be loaded first.
// Stall:
//   Each stage advances when the one after it is empty or moving, so up to
//   four pixel items are held while result_out.ready is low; then
//   pixel_in.ready drops.
module pixel_dark_gain_correction_core import pdgc_pkg::*; #(
  parameter int FRAME_PIXELS = 16384,
  parameter int GAIN_SHIFT   = 12,
  parameter int GAIN_BITS    = 16
) (
  input  logic              clk,
  input  logic              rst,
  pdgc_pixel_if.sink        pixel_in,
  pdgc_result_if.source     result_out,
  pdgc_cfg_if.sink          cfg
);

  localparam int CNT_W   = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int ENTRY_W = ADC_W + GAIN_BITS;
  localparam int TADDR_W = $clog2(TABLE_DEPTH);
  localparam int PROD_W  = DIFF_W + GAIN_BITS + 1;

  localparam logic [CNT_W-1:0]         CNT_LAST = CNT_W'(FRAME_PIXELS - 1);
  localparam logic signed [PROD_W-1:0] LIM_HI   = PROD_W'(SAT_HI);
  localparam logic signed [PROD_W-1:0] LIM_LO   = PROD_W'(SAT_LO);

  // configuration
  logic dark_enable, gain_enable, load_enable;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dark_enable <= 1'b0;
      gain_enable <= 1'b0;
      load_enable <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.addr)
        CFG_DARK_ENABLE: dark_enable <= cfg.data[0];
        CFG_GAIN_ENABLE: gain_enable <= cfg.data[0];
        CFG_LOAD_ENABLE: load_enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic v1, v2, v3, ov;
  logic adv1, adv2, adv3, adv_o;
  logic in_fire, pix_fire, cal_fire;

  assign adv_o = !ov || result_out.ready;
  assign adv3  = !v3 || adv_o;
  assign adv2  = !v2 || adv3;
  assign adv1  = !v1 || adv2;

  assign pixel_in.ready = adv1;
  assign in_fire  = pixel_in.valid && adv1;
  assign pix_fire = in_fire && (pixel_in.kind == KIND_PIXEL);
  assign cal_fire = in_fire && (pixel_in.kind == KIND_CAL) && load_enable;

  // pixel counter, table address from its low PIX_W bits
  logic [CNT_W-1:0]       cnt;
  logic [CNT_W-1:0]       cnt_next;
  logic [PIX_W+CNT_W-1:0] cnt_ext;

  assign cnt_ext  = {{PIX_W{1'b0}}, cnt};
  assign cnt_next = (cnt == CNT_LAST) ? '0 : cnt + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (pix_fire) begin
      cnt <= cnt_next;
    end
  end

  // calibration table
  logic [CAL_GAIN_W+GAIN_BITS-1:0] gain_ext;
  logic [ENTRY_W-1:0]              wr_entry;
  logic [TADDR_W-1:0]              wr_addr, rd_addr;
  logic [ENTRY_W-1:0]              rd_entry;

  assign gain_ext = {{GAIN_BITS{1'b0}}, pixel_in.cal_gain};
  assign wr_entry = {pixel_in.cal_dark, gain_ext[GAIN_BITS-1:0]};
  assign wr_addr  = {pixel_in.cal_range, pixel_in.cal_index};
  assign rd_addr  = {pixel_in.gain_bit, cnt_ext[PIX_W-1:0]};

  pdgc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (cal_fire),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .re    (pix_fire),
    .raddr (rd_addr),
    .rdata (rd_entry)
  );

  // stage 1: table data arrives
  logic [ADC_W-1:0] adc1;
  logic             gbit1, last1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= pix_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_fire) begin
      adc1  <= pixel_in.adc;
      gbit1 <= pixel_in.gain_bit;
      last1 <= pixel_in.last_in;
    end
  end

  // stage 2: dark subtract
  logic [ADC_W-1:0]         dark_rd;
  logic [GAIN_BITS-1:0]     gain_rd;
  logic signed [DIFF_W-1:0] diff_next, diff2;
  logic [GAIN_BITS-1:0]     gain2;
  logic                     gbit2, last2;

  assign dark_rd   = rd_entry[ENTRY_W-1:GAIN_BITS];
  assign gain_rd   = rd_entry[GAIN_BITS-1:0];
  assign diff_next = dark_enable ? $signed({1'b0, adc1}) - $signed({1'b0, dark_rd})
                                 : $signed({1'b0, adc1});

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      diff2 <= diff_next;
      gain2 <= gain_rd;
      gbit2 <= gbit1;
      last2 <= last1;
    end
  end

  // stage 3: gain multiply (pass-through when gain is off)
  logic signed [PROD_W-1:0] prod_next, prod3;
  logic                     gbit3, last3;

  assign prod_next = gain_enable ? PROD_W'(diff2) * PROD_W'($signed({1'b0, gain2}))
                                 : PROD_W'(diff2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      prod3 <= prod_next;
      gbit3 <= gbit2;
      last3 <= last2;
    end
  end

  // output register: floor shift (when gain is on), then clamp
  logic signed [PROD_W-1:0] scaled, clamped;

  always_comb begin
    scaled = gain_enable ? (prod3 >>> GAIN_SHIFT) : prod3;
    if (scaled > LIM_HI) begin
      clamped = LIM_HI;
    end else if (scaled < LIM_LO) begin
      clamped = LIM_LO;
    end else begin
      clamped = scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (adv_o) begin
      ov <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_o && v3) begin
      result_out.corrected <= clamped[OUT_W-1:0];
      result_out.gain_out  <= gbit3;
      result_out.last_out  <= last3;
    end
  end

  assign result_out.valid = ov;

endmodule

### hdl/pdgc_checker.sv
// Port-level checker for pixel_dark_gain_correction_core, with its bind.
// Tracks pixel items in flight against results delivered.
// Depends on pdgc_pkg and the pdgc_if.sv interfaces.
module pdgc_checker import pdgc_pkg::*; (
  input logic            clk,
  input logic            rst,
  pdgc_pixel_if.sink     pixel_in,
  pdgc_result_if.source  result_out
);

  localparam int OUTST_W = $clog2(PIPE_DEPTH + 1);

  logic [OUTST_W-1:0] outst;
  logic               pix_acc, res_acc;

  assign pix_acc = pixel_in.valid && pixel_in.ready && (pixel_in.kind == KIND_PIXEL);
  assign res_acc = result_out.valid && result_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outst <= '0;
    end else begin
      outst <= outst + OUTST_W'(pix_acc) - OUTST_W'(res_acc);
    end
  end

  // nothing comes out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_out.valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && !result_out.ready |=>
      result_out.valid && $stable(result_out.corrected) &&
      $stable(result_out.gain_out) && $stable(result_out.last_out))
    else $error("stalled result changed");

  // every result belongs to an accepted pixel item
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> outst != '0)
    else $error("result without pending pixel item");

  // pipeline holds at most four pixel items
  a_capacity: assert property (@(posedge clk) disable iff (rst)
    outst <= OUTST_W'(PIPE_DEPTH))
    else $error("more pixel items in flight than pipeline stages");

endmodule

bind pixel_dark_gain_correction_core pdgc_checker u_pdgc_checker (
  .clk        (clk),
  .rst        (rst),
  .pixel_in   (pixel_in),
  .result_out (result_out)
);
